[design/rmu_pkg.sv]
// Shared constants, codes and control types for the RMS current meter.
`default_nettype none
package rmu_pkg;

  // Field widths.
  localparam int unsigned ADC_BITS  = 10;
  localparam int unsigned VALUE_W   = 13;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned SUM_W     = 33;
  localparam int unsigned CAL_SUM_W = 23;
  localparam int unsigned WIDE_W    = 64;
  localparam int unsigned MUL_W     = 33;
  localparam int unsigned ROOT_W    = 32;
  localparam int unsigned SREM_W    = 34;
  localparam int unsigned STEP_W    = 7;

  // Measurement constants.
  localparam int unsigned MAX_WINDOW   = 4096;
  localparam int unsigned CAL_SAMPLES  = 5000;
  localparam int unsigned SCALE_DEN    = 4000;
  // Square of the scale numerator 27027.
  localparam int unsigned SCALE_SQ     = 730458729;
  localparam int unsigned VALUE_MAX    = 8191;
  localparam int unsigned COUNT_RESET  = 1000;
  localparam int unsigned OFFSET_RESET = 512;

  // Reciprocal division by constants. floor(x / 5000) equals
  // (x * CAL_RECIP) >> CAL_SHIFT for every calibration sum, and floor(y / 125)
  // equals (y * SCALE_RECIP) >> SCALE_SHIFT for y below 2^20. A root of
  // ROOT_SAT or more scales past the largest value and saturates.
  localparam int unsigned CAL_PROD_W    = 2 * CAL_SUM_W;
  localparam int unsigned CAL_RECIP     = 6871948;
  localparam int unsigned CAL_SHIFT     = 35;
  localparam int unsigned SCALE_PRE     = 5;
  localparam int unsigned SCALE_Y_W     = 20;
  localparam int unsigned SCALE_RECIP_W = 21;
  localparam int unsigned SCALE_PROD_W  = SCALE_Y_W + SCALE_RECIP_W;
  localparam int unsigned SCALE_RECIP   = 1073742;
  localparam int unsigned SCALE_SHIFT   = 27;
  localparam int unsigned ROOT_SAT      = SCALE_DEN * (VALUE_MAX + 1);

  // Iteration counts of the serial units.
  localparam int unsigned MUL_STEPS   = MUL_W;
  localparam int unsigned DIV_STEPS   = WIDE_W;
  localparam int unsigned SQRT_STEPS  = WIDE_W / 2;

  // Input opcodes and result kinds.
  localparam logic OPCODE_MEASURE = 1'b0;
  localparam logic OPCODE_CAL     = 1'b1;
  localparam logic KIND_RMS       = 1'b0;
  localparam logic KIND_OFFSET    = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_UPDATE,
    OP_CAL_LOAD,
    OP_MUL_LOAD,
    OP_MUL_STEP,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_SQRT_LOAD,
    OP_SQRT_STEP,
    OP_SCALE,
    OP_EMIT_CAL,
    OP_EMIT_RMS
  } dp_op_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
  } rmu_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic is_cal;
    logic win_done;
    logic cal_done;
    logic out_busy;
  } rmu_stat_t;

endpackage
`default_nettype wire

[design/rmu_if.sv]
// Stream interfaces for sample input and result output.
`default_nettype none
interface rmu_in_if
  import rmu_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [ADC_BITS-1:0] sample;

  modport source (output valid, opcode, sample, input ready);
  modport sink (input valid, opcode, sample, output ready);
endinterface

interface rmu_out_if
  import rmu_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [VALUE_W-1:0] value;

  modport source (output valid, result_kind, value, input ready);
  modport sink (input valid, result_kind, value, output ready);
endinterface
`default_nettype wire

[design/rmu_datapath.sv]
// Datapath: accumulators, serial multiplier, divider and square root, result register.
`default_nettype none
module rmu_datapath
  import rmu_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_data_i,
  input  wire rmu_cmd_t     cmd_i,
  output rmu_stat_t         stat_o,
  rmu_in_if.sink            in_i,
  rmu_out_if.source         out_o
);

  localparam logic [CNT_W-1:0]   CAL_DIVISOR   = CNT_W'(CAL_SAMPLES);
  localparam logic [CNT_W-1:0]   WINDOW_MAX    = CNT_W'(MAX_WINDOW);
  localparam logic [CNT_W-1:0]   WINDOW_MIN    = CNT_W'(1);
  localparam logic [VALUE_W-1:0] VALUE_SAT     = VALUE_W'(VALUE_MAX);
  localparam logic [WIDE_W-1:0]  SCALE_SQ_W    = WIDE_W'(SCALE_SQ);
  localparam logic [CAL_SUM_W-1:0]     CAL_RECIP_C   = CAL_SUM_W'(CAL_RECIP);
  localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP_C = SCALE_RECIP_W'(SCALE_RECIP);
  localparam logic [ROOT_W-1:0]        ROOT_SAT_C    = ROOT_W'(ROOT_SAT);

  // Architectural state.
  logic [CNT_W-1:0]     sample_count_q, sample_count_d;
  logic [ADC_BITS-1:0]  zero_offset_q, zero_offset_d;
  logic [SUM_W-1:0]     square_sum_q, square_sum_d;
  logic [CNT_W-1:0]     window_count_q, window_count_d;
  logic [CAL_SUM_W-1:0] calib_sum_q, calib_sum_d;
  logic [CNT_W-1:0]     calib_count_q, calib_count_d;
  logic                 out_valid_q, out_valid_d;

  // Working registers.
  logic                 opcode_q, opcode_d;
  logic [ADC_BITS-1:0]  sample_q, sample_d;
  logic [WIDE_W-1:0]    d_q, d_d;
  logic [MUL_W-1:0]     m_q, m_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     div_q, div_d;
  logic [ROOT_W-1:0]    root_q, root_d;
  logic [SREM_W-1:0]    srem_q, srem_d;
  logic                 out_kind_q, out_kind_d;
  logic [VALUE_W-1:0]   out_value_q, out_value_d;

  logic                  in_fire;
  logic [CNT_W-1:0]      n_eff;
  logic [ADC_BITS-1:0]   diff;
  logic [2*ADC_BITS-1:0] sq;
  logic [CNT_W:0]        div_t;
  logic [CNT_W:0]        div_sub;
  logic                  div_ge;
  logic [SREM_W+1:0]     sqrt_t;
  logic [SREM_W+1:0]     sqrt_trial;
  logic                  sqrt_ge;
  logic [WIDE_W-1:0]     mul_sum;
  logic [CAL_PROD_W-1:0]   cal_prod;
  logic [ADC_BITS-1:0]     cal_quot;
  logic [SCALE_Y_W-1:0]    scale_y;
  logic [SCALE_PROD_W-1:0] scale_prod;
  logic [VALUE_W-1:0]      scale_quot;
  logic                    scale_sat;

  assign in_fire     = in_i.valid && in_i.ready;
  assign in_i.ready  = cmd_i.accept;
  assign out_o.valid = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.value = out_value_q;

  always_comb begin
    if (sample_count_q == '0) begin
      n_eff = WINDOW_MIN;
    end else if (sample_count_q > WINDOW_MAX) begin
      n_eff = WINDOW_MAX;
    end else begin
      n_eff = sample_count_q;
    end
  end

  assign diff = (sample_q >= zero_offset_q) ? (sample_q - zero_offset_q)
                                            : (zero_offset_q - sample_q);
  assign sq   = (2*ADC_BITS)'(diff) * (2*ADC_BITS)'(diff);

  // Restoring division step: one quotient bit shifts into the low end of d_q.
  assign div_t   = {rem_q, d_q[WIDE_W-1]};
  assign div_ge  = div_t >= {1'b0, div_q};
  assign div_sub = div_t - {1'b0, div_q};

  // Digit-by-digit square root: two radicand bits leave the top of d_q per step.
  assign sqrt_t     = {srem_q, d_q[WIDE_W-1 -: 2]};
  assign sqrt_trial = {2'b00, root_q, 2'b01};
  assign sqrt_ge    = sqrt_t >= sqrt_trial;

  // Shift-and-add product, most significant multiplier bit first.
  assign mul_sum = {d_q[WIDE_W-2:0], 1'b0} + (m_q[MUL_W-1] ? SCALE_SQ_W : '0);

  // Mean of the calibration run by reciprocal multiplication.
  assign cal_prod = CAL_PROD_W'(calib_sum_q) * CAL_PROD_W'(CAL_RECIP_C);
  assign cal_quot = cal_prod[CAL_SHIFT +: ADC_BITS];

  // Root divided by 4000: a shift by 5, then a reciprocal multiply for 125.
  assign scale_sat  = root_q >= ROOT_SAT_C;
  assign scale_y    = root_q[SCALE_PRE +: SCALE_Y_W];
  assign scale_prod = SCALE_PROD_W'(scale_y) * SCALE_PROD_W'(SCALE_RECIP_C);
  assign scale_quot = scale_prod[SCALE_SHIFT +: VALUE_W];

  assign stat_o.in_fire  = in_fire;
  assign stat_o.is_cal   = (opcode_q == OPCODE_CAL);
  assign stat_o.win_done = ({1'b0, window_count_q} + 1'b1) >= {1'b0, n_eff};
  assign stat_o.cal_done = ({1'b0, calib_count_q} + 1'b1) >= {1'b0, CAL_DIVISOR};
  assign stat_o.out_busy = out_valid_q && !out_o.ready;

  always_comb begin
    sample_count_d = sample_count_q;
    zero_offset_d  = zero_offset_q;
    square_sum_d   = square_sum_q;
    window_count_d = window_count_q;
    calib_sum_d    = calib_sum_q;
    calib_count_d  = calib_count_q;
    out_valid_d    = out_valid_q;
    opcode_d       = opcode_q;
    sample_d       = sample_q;
    d_d            = d_q;
    m_d            = m_q;
    rem_d          = rem_q;
    div_d          = div_q;
    root_d         = root_q;
    srem_d         = srem_q;
    out_kind_d     = out_kind_q;
    out_value_d    = out_value_q;

    if (cfg_we_i) begin
      sample_count_d = cfg_data_i;
    end
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      opcode_d = in_i.opcode;
      sample_d = in_i.sample;
    end

    case (cmd_i.op)
      OP_UPDATE: begin
        if (opcode_q == OPCODE_CAL) begin
          calib_sum_d   = calib_sum_q + CAL_SUM_W'(sample_q);
          calib_count_d = calib_count_q + 1'b1;
        end else begin
          square_sum_d   = square_sum_q + SUM_W'(sq);
          window_count_d = window_count_q + 1'b1;
        end
      end
      OP_CAL_LOAD: begin
        d_d           = WIDE_W'(cal_quot);
        calib_sum_d   = '0;
        calib_count_d = '0;
      end
      OP_MUL_LOAD: begin
        d_d            = '0;
        m_d            = square_sum_q;
        square_sum_d   = '0;
        window_count_d = '0;
      end
      OP_MUL_STEP: begin
        d_d = mul_sum;
        m_d = {m_q[MUL_W-2:0], 1'b0};
      end
      OP_DIV_LOAD: begin
        rem_d = '0;
        div_d = n_eff;
      end
      OP_DIV_STEP: begin
        d_d   = {d_q[WIDE_W-2:0], div_ge};
        rem_d = div_ge ? div_sub[CNT_W-1:0] : div_t[CNT_W-1:0];
      end
      OP_SQRT_LOAD: begin
        root_d = '0;
        srem_d = '0;
      end
      OP_SQRT_STEP: begin
        d_d    = {d_q[WIDE_W-3:0], 2'b00};
        root_d = {root_q[ROOT_W-2:0], sqrt_ge};
        srem_d = sqrt_ge ? SREM_W'(sqrt_t - sqrt_trial) : sqrt_t[SREM_W-1:0];
      end
      OP_SCALE: begin
        d_d = scale_sat ? WIDE_W'(VALUE_SAT) : WIDE_W'(scale_quot);
      end
      OP_EMIT_CAL: begin
        zero_offset_d = d_q[ADC_BITS-1:0];
        out_kind_d    = KIND_OFFSET;
        out_value_d   = {{(VALUE_W-ADC_BITS){1'b0}}, d_q[ADC_BITS-1:0]};
        out_valid_d   = 1'b1;
      end
      OP_EMIT_RMS: begin
        out_kind_d  = KIND_RMS;
        out_value_d = (d_q[ROOT_W-1:VALUE_W] != '0) ? VALUE_SAT : d_q[VALUE_W-1:0];
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= CNT_W'(COUNT_RESET);
      zero_offset_q  <= ADC_BITS'(OFFSET_RESET);
      square_sum_q   <= '0;
      window_count_q <= '0;
      calib_sum_q    <= '0;
      calib_count_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      sample_count_q <= sample_count_d;
      zero_offset_q  <= zero_offset_d;
      square_sum_q   <= square_sum_d;
      window_count_q <= window_count_d;
      calib_sum_q    <= calib_sum_d;
      calib_count_q  <= calib_count_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opcode_q    <= opcode_d;
    sample_q    <= sample_d;
    d_q         <= d_d;
    m_q         <= m_d;
    rem_q       <= rem_d;
    div_q       <= div_d;
    root_q      <= root_d;
    srem_q      <= srem_d;
    out_kind_q  <= out_kind_d;
    out_value_q <= out_value_d;
  end

endmodule
`default_nettype wire

[design/rmu_ctrl.sv]
// Controller state machine that sequences accumulation, the calibration end and the window-end computation.
`default_nettype none
module rmu_ctrl
  import rmu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire rmu_stat_t stat_i,
  output rmu_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_UPDATE     = 4'd1;
  localparam logic [3:0] S_CAL_LOAD   = 4'd2;
  localparam logic [3:0] S_CAL_EMIT   = 4'd3;
  localparam logic [3:0] S_MUL_LOAD   = 4'd4;
  localparam logic [3:0] S_MUL        = 4'd5;
  localparam logic [3:0] S_DIV_LOAD   = 4'd6;
  localparam logic [3:0] S_DIV        = 4'd7;
  localparam logic [3:0] S_SQRT_LOAD  = 4'd8;
  localparam logic [3:0] S_SQRT       = 4'd9;
  localparam logic [3:0] S_SCALE      = 4'd10;
  localparam logic [3:0] S_RMS_EMIT   = 4'd11;

  localparam logic [STEP_W-1:0] MUL_LAST   = STEP_W'(MUL_STEPS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST  = STEP_W'(SQRT_STEPS - 1);

  logic [3:0]        state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              last;

  assign last = (cnt_q == '0);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o.accept = 1'b0;
    cmd_o.op     = OP_NONE;

    case (state_q)
      S_IDLE: begin
        cmd_o.accept = 1'b1;
        if (stat_i.in_fire) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.op = OP_UPDATE;
        if (stat_i.is_cal) begin
          state_d = stat_i.cal_done ? S_CAL_LOAD : S_IDLE;
        end else begin
          state_d = stat_i.win_done ? S_MUL_LOAD : S_IDLE;
        end
      end
      S_CAL_LOAD: begin
        cmd_o.op = OP_CAL_LOAD;
        state_d  = S_CAL_EMIT;
      end
      S_CAL_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_EMIT_CAL;
          state_d  = S_IDLE;
        end
      end
      S_MUL_LOAD: begin
        cmd_o.op = OP_MUL_LOAD;
        cnt_d    = MUL_LAST;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL_STEP;
        cnt_d    = cnt_q - 1'b1;
        if (last) begin
          state_d = S_DIV_LOAD;
        end
      end
      S_DIV_LOAD: begin
        cmd_o.op = OP_DIV_LOAD;
        cnt_d    = DIV_LAST;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q - 1'b1;
        if (last) begin
          state_d = S_SQRT_LOAD;
        end
      end
      S_SQRT_LOAD: begin
        cmd_o.op = OP_SQRT_LOAD;
        cnt_d    = SQRT_LAST;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q - 1'b1;
        if (last) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.op = OP_SCALE;
        state_d  = S_RMS_EMIT;
      end
      S_RMS_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_EMIT_RMS;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

[design/rms_current_meter_unit.sv]
// Top level: true-RMS current meter with zero-offset calibration.
// A sample that does not close a window or calibration run passes through the accept and update states.
// A window end adds a 33-step multiply, a 64-step divide by the clamped window length
// and a 32-step square root, one bit per cycle, plus load, scale and emit states.
// A calibration end adds a load and an emit state; either emit state waits while an earlier result is held.
// Reset clears the accumulators, sets the offset to mid-scale and the window length to 1000.
`default_nettype none
module rms_current_meter_unit
  import rmu_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  rmu_in_if.sink                in_i,
  rmu_out_if.source             out_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_data_i
);

  rmu_cmd_t  cmd;
  rmu_stat_t stat;

  rmu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  rmu_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_i       (in_i),
    .out_o      (out_o)
  );

  // Every accepted transaction is followed by an update cycle that takes no input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted during the update cycle");

  // A new result only appears when no input could be taken just before it rises.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result raised while the input was open");

  // An offset result is a mean of ADC readings and fits the ADC range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.result_kind == KIND_OFFSET)) |->
      (out_o.value[VALUE_W-1:ADC_BITS] == '0))
    else $error("offset result out of ADC range");

endmodule
`default_nettype wire

[tb/rms_current_meter_unit_test.sv]
// Self-checking testbench for the RMS current meter: directed table, then randomized sample streams.
`default_nettype none
module rms_current_meter_unit_test;
  import rmu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD    = 20;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned TAIL_CYCLES   = 200;
  localparam int unsigned MAIN_ITEMS    = 1150;
  localparam int unsigned CALM_ITEMS    = 150;
  localparam int unsigned NUM_ROWS      = 25;

  // Independent copy of the meter arithmetic.
  localparam int unsigned      WINDOW_CAP = 4096;
  localparam int unsigned      CAL_RUN    = 5000;
  localparam int unsigned      ADC_MAX    = (1 << ADC_BITS) - 1;
  localparam int unsigned      LEN_MAX    = (1 << CNT_W) - 1;
  localparam longint unsigned  AMP_NUM    = 27027;
  localparam longint unsigned  AMP_DEN    = 4000;
  localparam longint unsigned  AMP_LIMIT  = (1 << VALUE_W) - 1;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
  } reading_t;

  typedef enum logic [0:0] {ROW_CFG, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CNT_W-1:0]    len;
    logic                op;
    logic [ADC_BITS-1:0] smp;
    logic                typed;
    logic [VALUE_W-1:0]  want;
  } step_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_data_i = '0;

  rmu_in_if  in_if ();
  rmu_out_if out_if ();

  rms_current_meter_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Predictor state.
  logic [CNT_W-1:0]    window_len = CNT_W'(1000);
  logic [ADC_BITS-1:0] zero_level = ADC_BITS'(512);
  logic [32:0]         energy = '0;
  logic [CNT_W-1:0]    window_fill = '0;
  logic [22:0]         cal_total = '0;
  logic [CNT_W-1:0]    cal_taken = '0;

  reading_t    awaited_readings[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          feed_idles = 1'b0;
  bit          drain_stalls = 1'b0;
  int unsigned pause_rate = 0;
  int unsigned stall_left = 0;

  // Largest v with (4000 v)^2 * n <= energy * 27027^2, saturated at the field maximum.
  function automatic logic [VALUE_W-1:0] rms_amps(input logic [32:0] sum,
                                                 input int unsigned n);
    logic [127:0]    bound;
    logic [127:0]    t;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = AMP_LIMIT;
    bound = 128'(sum) * 128'(AMP_NUM) * 128'(AMP_NUM);
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      t = 128'(mid) * 128'(AMP_DEN);
      if (t * t * 128'(n) <= bound) lo = mid;
      else hi = mid - 1;
    end
    return VALUE_W'(lo);
  endfunction

  task automatic account_sample(input logic op, input logic [ADC_BITS-1:0] smp,
                                output bit emits, output reading_t r);
    logic [ADC_BITS-1:0] dev;
    int unsigned         n;
    emits = 1'b0;
    r = '0;
    if (op == OPCODE_CAL) begin
      cal_total = cal_total + 23'(smp);
      cal_taken = cal_taken + 1'b1;
      if (cal_taken >= CAL_RUN) begin
        zero_level = ADC_BITS'(cal_total / CAL_RUN);
        cal_total = '0;
        cal_taken = '0;
        emits = 1'b1;
        r.kind = KIND_OFFSET;
        r.value = VALUE_W'(zero_level);
      end
    end else begin
      dev = (smp >= zero_level) ? smp - zero_level : zero_level - smp;
      n = window_len;
      if (n == 0) n = 1;
      if (n > WINDOW_CAP) n = WINDOW_CAP;
      energy = energy + 33'(dev) * 33'(dev);
      window_fill = window_fill + 1'b1;
      if (window_fill >= n) begin
        emits = 1'b1;
        r.kind = KIND_RMS;
        r.value = rms_amps(energy, n);
        energy = '0;
        window_fill = '0;
      end
    end
  endtask

  function automatic logic [ADC_BITS-1:0] pick_sample();
    int unsigned near;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ADC_BITS'(ADC_MAX);
      2: begin
        near = zero_level + $urandom_range(0, 6);
        if (near < 3) return '0;
        if (near - 3 > ADC_MAX) return ADC_BITS'(ADC_MAX);
        return ADC_BITS'(near - 3);
      end
      default: return ADC_BITS'($urandom);
    endcase
  endfunction

  function automatic void log_mismatch(input string what, input int unsigned want,
                                       input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("cycle %0d: %s: expected %0d, got %0d", cycle_count, what, want, got);
  endfunction

  // Drives one sample transaction and waits until the block takes it.
  task automatic feed_sample(input logic op, input logic [ADC_BITS-1:0] smp,
                             input bit use_typed, input reading_t typed);
    int unsigned gap;
    bit          settle;
    bit          emits;
    reading_t    predicted;
    gap = (feed_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    settle = pause_rate != 0 && $urandom_range(1, pause_rate) == 1 &&
             awaited_readings.size() != 0;
    if (gap != 0 || settle) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      while (settle && awaited_readings.size() != 0) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.sample <= smp;
    account_sample(op, smp, emits, predicted);
    if (use_typed) awaited_readings.push_back(typed);
    else if (emits) awaited_readings.push_back(predicted);
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // The length register is only written once the block has gone quiet.
  task automatic set_window_len(input logic [CNT_W-1:0] len);
    in_if.valid <= 1'b0;
    while (awaited_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_data_i <= len;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    window_len = len;
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) stall_left--;
    else if (drain_stalls && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 9);
    out_if.ready <= (stall_left == 0);
  end

  always @(posedge clk_i) begin : check_results
    reading_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (awaited_readings.size() == 0) begin
        log_mismatch("result with nothing awaited, value", 0, out_if.value);
      end else begin
        want = awaited_readings.pop_front();
        if (out_if.result_kind !== want.kind)
          log_mismatch("result_kind", want.kind, out_if.result_kind);
        if (out_if.value !== want.value)
          log_mismatch("value", want.value, out_if.value);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    step_row_t        script [NUM_ROWS];
    reading_t         typed_reading;
    logic [CNT_W-1:0] len;
    int unsigned      main_fed;

    in_if.valid  = 1'b0;
    in_if.opcode = OPCODE_MEASURE;
    in_if.sample = '0;
    out_if.ready = 1'b0;

    // Typed expectations assume the mid-scale offset left by reset and windows of one.
    script = '{
      '{ROW_CFG,    13'd1,    OPCODE_MEASURE, 10'd0,    1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd512,  1'b1, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd0,    1'b1, 13'd3459},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd1023, 1'b1, 13'd3452},
      '{ROW_CFG,    13'd0,    OPCODE_MEASURE, 10'd0,    1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd1023, 1'b1, 13'd3452},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd0,    1'b1, 13'd3459},
      '{ROW_SAMPLE, 13'd0,    OPCODE_CAL,     10'd1023, 1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_CAL,     10'd0,    1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd700,  1'b1, 13'd1270},
      '{ROW_CFG,    13'd3,    OPCODE_MEASURE, 10'd0,    1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd0,    1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_CAL,     10'd341,  1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd1023, 1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd682,  1'b0, 13'd0},
      '{ROW_CFG,    13'd1000, OPCODE_MEASURE, 10'd0,    1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd100,  1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd900,  1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd512,  1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd511,  1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd513,  1'b0, 13'd0},
      '{ROW_CFG,    13'd2,    OPCODE_MEASURE, 10'd0,    1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd256,  1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd1,    1'b0, 13'd0},
      '{ROW_SAMPLE, 13'd0,    OPCODE_MEASURE, 10'd1022, 1'b0, 13'd0}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    feed_idles = 1'b1;
    drain_stalls = 1'b1;
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        set_window_len(script[i].len);
      end else begin
        typed_reading.kind = KIND_RMS;
        typed_reading.value = script[i].want;
        feed_sample(script[i].op, script[i].smp, script[i].typed, typed_reading);
      end
    end

    main_fed = 0;
    pause_rate = 40;
    while (main_fed < MAIN_ITEMS - CALM_ITEMS) begin
      feed_idles = $urandom_range(0, 3) != 0;
      drain_stalls = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 19))
        0, 1:                len = '0;
        2:                   len = CNT_W'($urandom_range(WINDOW_CAP + 1, LEN_MAX));
        3, 4:                len = CNT_W'($urandom_range(100, 300));
        5, 6, 7, 8, 9, 10:   len = CNT_W'($urandom_range(9, 64));
        default:             len = CNT_W'($urandom_range(1, 8));
      endcase
      set_window_len(len);
      repeat ($urandom_range(50, 150)) begin
        feed_sample(($urandom_range(0, 7) == 0) ? OPCODE_CAL : OPCODE_MEASURE,
                    pick_sample(), 1'b0, '0);
        main_fed++;
      end
    end

    // Closing stretch at full rate on both sides.
    feed_idles = 1'b0;
    drain_stalls = 1'b0;
    pause_rate = 0;
    set_window_len(CNT_W'($urandom_range(1, 8)));
    repeat (CALM_ITEMS)
      feed_sample(($urandom_range(0, 7) == 0) ? OPCODE_CAL : OPCODE_MEASURE,
                  pick_sample(), 1'b0, '0);

    in_if.valid <= 1'b0;
    while (awaited_readings.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaited_readings.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

[rms_current_meter_unit.f]
design/rmu_pkg.sv
design/rmu_if.sv
design/rmu_datapath.sv
design/rmu_ctrl.sv
design/rms_current_meter_unit.sv
tb/rms_current_meter_unit_test.sv
